@@ sv/anagram_checker_macros.svh @@
// Assertion macros shared by the anagram checker RTL.
// Each macro expands to one labeled concurrent assertion on the rising clock edge.
`ifndef ANAGRAM_CHECKER_MACROS_SVH
`define ANAGRAM_CHECKER_MACROS_SVH

// The condition holds in the same cycle as the trigger.
`define AC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The condition holds in the cycle after the trigger.
`define AC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/ac_pkg.sv @@
// Shared types and constants of the anagram checker.
// No dependencies; ac_ctrl, ac_datapath and anagram_checker import this package.
package ac_pkg;

	// Number of histogram bins, one per byte value.
	localparam int BINS = 256;
	localparam int CH_W = 8;
	localparam int NZ_W = $clog2(BINS + 1);

	// Default string length limit.
	localparam int MAX_LEN_DEF = 256;

	// Command codes of an input beat.
	typedef enum logic [1:0] {
		CMD_FIRST  = 2'd0,
		CMD_SECOND = 2'd1,
		CMD_FINISH = 2'd2
	} cmd_e;

	// Input beat payload.
	typedef struct packed {
		logic [1:0]      command;
		logic [CH_W-1:0] ch;
	} in_item_t;

	// Result beat payload.
	typedef struct packed {
		logic is_anagram;
		logic overflow;
	} out_item_t;

	// Controller states.
	typedef enum logic {
		ST_IDLE,
		ST_WRITE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic rd_en;
		logic rd_sub;
		logic wr_en;
		logic finish;
		logic set_ovf;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic full_first;
		logic full_second;
		logic out_busy;
	} dp_status_t;

endpackage

@@ sv/ac_stream_if.sv @@
// Valid/ready stream channel used for the input and result beats.
// Depends on nothing; the payload type is a parameter.
interface ac_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ sv/ac_ctrl.sv @@
// Controller state machine of the anagram checker.
// Depends on ac_pkg and ac_stream_if; drives input ready and datapath commands.
module ac_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	ac_stream_if.sink          req,
	input  ac_pkg::dp_status_t status,
	output ac_pkg::ctrl_cmd_t  cmd
);
	import ac_pkg::*;

	state_t state_q;
	state_t state_next;
	logic   accept;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	assign accept = req.valid && req.ready;

	// Next state, ready and datapath commands.
	always_comb begin
		state_next = state_q;
		req.ready  = 1'b0;
		cmd        = '0;
		case (state_q)
			ST_IDLE: begin
				// A finish beat needs room in the result register.
				req.ready = !((req.data.command == CMD_FINISH) && status.out_busy);
				if (accept) begin
					case (req.data.command)
						CMD_FIRST: begin
							if (status.full_first) begin
								cmd.set_ovf = 1'b1;
							end else begin
								cmd.rd_en  = 1'b1;
								state_next = ST_WRITE;
							end
						end
						CMD_SECOND: begin
							if (status.full_second) begin
								cmd.set_ovf = 1'b1;
							end else begin
								cmd.rd_en  = 1'b1;
								cmd.rd_sub = 1'b1;
								state_next = ST_WRITE;
							end
						end
						CMD_FINISH: begin
							cmd.finish = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			ST_WRITE: begin
				cmd.wr_en  = 1'b1;
				state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

endmodule

@@ sv/ac_datapath.sv @@
// Datapath of the anagram checker: histogram memory, lengths and result register.
// Depends on ac_pkg and ac_stream_if; obeys commands from ac_ctrl.
module ac_datapath #(
	parameter int MAX_LEN = ac_pkg::MAX_LEN_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [ac_pkg::CH_W-1:0] ch,
	input  ac_pkg::ctrl_cmd_t       cmd,
	output ac_pkg::dp_status_t      status,
	ac_stream_if.source             rsp
);
	import ac_pkg::*;

	localparam int LEN_W = $clog2(MAX_LEN + 1);
	localparam int BIN_W = LEN_W + 1;

	logic [BIN_W-1:0] mem [BINS];
	logic [BINS-1:0]  bin_vld_q;
	logic [BIN_W-1:0] rd_q;
	logic             rd_vld_q;
	logic [CH_W-1:0]  addr_q;
	logic             sub_q;
	logic [BIN_W-1:0] old_bin;
	logic [BIN_W-1:0] new_bin;
	logic [LEN_W-1:0] len_first_q;
	logic [LEN_W-1:0] len_second_q;
	logic [NZ_W-1:0]  nonzero_q;
	logic             ovf_q;
	logic             out_vld_q;
	out_item_t        out_q;
	logic             equal;

	// Registered read of the addressed bin.
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_q   <= mem[ch];
			addr_q <= ch;
			sub_q  <= cmd.rd_sub;
		end
	end

	// Write back of the updated bin.
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[addr_q] <= new_bin;
		end
	end

	// A bin that is not valid reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (cmd.rd_en) begin
				rd_vld_q <= bin_vld_q[ch];
			end
			if (cmd.finish) begin
				bin_vld_q <= '0;
			end else if (cmd.wr_en) begin
				bin_vld_q[addr_q] <= 1'b1;
			end
		end
	end

	assign old_bin = rd_vld_q ? rd_q : '0;
	assign new_bin = sub_q ? (old_bin - BIN_W'(1)) : (old_bin + BIN_W'(1));

	// Lengths, count of nonzero bins and sticky overflow.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_first_q  <= '0;
			len_second_q <= '0;
			nonzero_q    <= '0;
			ovf_q        <= 1'b0;
		end else if (cmd.finish) begin
			len_first_q  <= '0;
			len_second_q <= '0;
			nonzero_q    <= '0;
			ovf_q        <= 1'b0;
		end else begin
			if (cmd.rd_en && !cmd.rd_sub) begin
				len_first_q <= len_first_q + LEN_W'(1);
			end
			if (cmd.rd_en && cmd.rd_sub) begin
				len_second_q <= len_second_q + LEN_W'(1);
			end
			if (cmd.set_ovf) begin
				ovf_q <= 1'b1;
			end
			// A bin leaving zero adds one; a bin returning to zero removes one.
			if (cmd.wr_en) begin
				if (old_bin == '0) begin
					nonzero_q <= nonzero_q + NZ_W'(1);
				end else if (new_bin == '0) begin
					nonzero_q <= nonzero_q - NZ_W'(1);
				end
			end
		end
	end

	assign equal = !ovf_q && (len_first_q == len_second_q) && (len_first_q != '0)
		&& (nonzero_q == '0);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.finish) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q.is_anagram <= equal;
			out_q.overflow   <= ovf_q;
		end
	end

	assign rsp.valid = out_vld_q;
	assign rsp.data  = out_q;

	assign status.full_first  = (len_first_q == LEN_W'(MAX_LEN));
	assign status.full_second = (len_second_q == LEN_W'(MAX_LEN));
	assign status.out_busy    = out_vld_q && !rsp.ready;

endmodule

@@ sv/anagram_checker.sv @@
// Top level of the anagram checker.
// Depends on ac_pkg, ac_stream_if, ac_ctrl, ac_datapath and the assertion macros.
//
// Input beats on req carry a command and a byte: a byte of the first string,
// a byte of the second string, or a finish. Command code three is ignored.
// A byte beat needs a read and a write back: the bin is read from the single-port
// histogram memory in the accept cycle and written back in the next, so req.ready
// is low during the write back. A byte dropped because its string already holds
// MAX_LEN bytes, an ignored beat and a finish need no write back and leave the controller idle.
// The result of a finish appears on rsp in the cycle after the finish is
// accepted. A count of nonzero bins is kept on every update, so a finish needs
// no scan of the histogram; it clears both lengths and the overflow flag at once,
// and all bins through per-bin valid bits.
// The result waits in an output register while rsp.ready is low; byte beats
// are still taken meanwhile, and only a further finish waits for the register.
// Reset clears all bins, lengths and flags at once; no clearing pass follows.
`include "anagram_checker_macros.svh"

module anagram_checker #(
	parameter int MAX_LEN = ac_pkg::MAX_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	ac_stream_if.sink   req,
	ac_stream_if.source rsp
);
	import ac_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	ac_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.status (status),
		.cmd    (cmd)
	);

	ac_datapath #(
		.MAX_LEN (MAX_LEN)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.ch     (req.data.ch),
		.cmd    (cmd),
		.status (status),
		.rsp    (rsp)
	);

	// An accepted finish yields a result in the next cycle.
	`AC_ASSERT_NEXT(a_finish_result, clk, arst_n, req.valid && req.ready && (req.data.command == CMD_FINISH), rsp.valid, "finish beat gave no result")
	// No new beat is taken while a bin write back is in progress.
	`AC_ASSERT_SAME(a_busy_write, clk, arst_n, cmd.wr_en, !req.ready, "input taken during bin write")
	// An overflowed result never reports an anagram.
	`AC_ASSERT_SAME(a_ovf_not_anagram, clk, arst_n, rsp.valid && rsp.data.overflow, !rsp.data.is_anagram, "overflow with anagram set")

endmodule
